// ----- rtl/jti_pkg.sv -----
package jti_pkg;

   localparam int JOINTS     = 6;
   localparam int MAX_POINTS = 256;
   localparam int ADDR_W     = $clog2(MAX_POINTS * JOINTS);
   localparam int DEPTH      = MAX_POINTS * JOINTS;
   localparam int ONE_Q16    = 65536;

   // Request kinds.
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  point_index;
      logic [2:0]  joint_index;
      logic signed [31:0] position_in;
      logic signed [31:0] velocity_in;
      logic [31:0] point_time_us;
      logic        is_last_point;
      logic [47:0] now_time_us;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  out_joint;
      logic signed [31:0] position_cmd;
      logic signed [31:0] velocity_cmd;
      logic        motion_done;
      logic        last_of_tick;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_CLAMP,
      ST_FRAC,
      ST_READ,
      ST_MUL,
      ST_SEND
   } state_type;

endpackage

// ----- rtl/joint_trajectory_interpolator_top.sv -----
// A load is written in the cycle it is accepted and gives no word; a tick while no
// trajectory is active gives no word either. Any other tick runs an 8-step segment divide
// and a 17-step fraction divide, one bit a cycle, both skipped when it ends the motion;
// each joint word then goes through the read, multiply and send states in turn.
// Loads can be accepted back to back while idle; a tick holds off requests until its
// last joint word is sent. Reset (synchronous, active high) clears the control state; the point memories are undefined until written.
module joint_trajectory_interpolator_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  jti_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output jti_pkg::rsp_word_type rsp_data
);

   localparam logic [jti_pkg::ADDR_W-1:0] JSTEP = jti_pkg::ADDR_W'(jti_pkg::JOINTS);
   localparam logic [2:0] JLAST = 3'(jti_pkg::JOINTS - 1);

   // Point memories.
   logic signed [31:0] pos_mem [jti_pkg::DEPTH];
   logic signed [31:0] vel_mem [jti_pkg::DEPTH];

   jti_pkg::state_type state_ff, state_in;
   logic [8:0]  cnt_ff, cnt_in;
   logic [31:0] total_ff, total_in;
   logic [47:0] start_ff, start_in;
   logic        pend_ff, pend_in;
   logic        active_ff, active_in;
   logic [47:0] t_ff, t_in;
   logic [7:0]  tnlo_ff, tnlo_in;
   logic [32:0] rem_ff, rem_in;
   logic [7:0]  q_ff, q_in;
   logic [16:0] frac_ff, frac_in;
   logic [4:0]  step_ff, step_in;
   logic [jti_pkg::ADDR_W-1:0] base_ff, base_in;
   logic [2:0]  joint_ff, joint_in;
   logic        end_ff, end_in;
   logic        rsp_valid_ff, rsp_valid_in;
   jti_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic signed [31:0] pa_ff, pb_ff, va_ff, vb_ff;
   logic signed [31:0] pa_keep_ff, va_keep_ff;
   logic signed [50:0] pprod_ff, vprod_ff;

   logic        req_fire, out_free, mem_we, rd_en, last_step;
   logic [jti_pkg::ADDR_W-1:0] wr_addr, rd_addr0, rd_addr1;
   logic [40:0] tn;
   logic [47:0] start_now;
   logic [32:0] div_r, div_r2;
   logic        div_ge;
   logic [7:0]  ind_c;
   logic [7:0]  last_pt;

   assign req_ready = (state_ff == jti_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // One restoring divide step against the total time.
   always_comb begin
      div_r = (state_ff == jti_pkg::ST_DIV) ? {rem_ff[31:0], tnlo_ff[7]} :
              ((step_ff == 5'd0) ? rem_ff : {rem_ff[31:0], 1'b0});
      div_ge = (div_r >= {1'b0, total_ff});
      div_r2 = div_ge ? (div_r - {1'b0, total_ff}) : div_r;
   end

   assign tn        = 41'(t_ff[31:0]) * 41'(cnt_ff);
   assign start_now = pend_ff ? req_data.now_time_us : start_ff;
   assign last_pt   = (cnt_ff != 9'd0) ? 8'(cnt_ff - 9'd1) : 8'd0;
   assign ind_c     = (q_ff == 8'(cnt_ff - 9'd1)) ? (q_ff - 8'd1) : q_ff;
   assign last_step = (state_ff == jti_pkg::ST_DIV) ? (step_ff == 5'd7) : (step_ff == 5'd16);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         jti_pkg::ST_IDLE: begin
            if (req_fire && req_data.req_type == jti_pkg::REQ_TICK && active_ff) begin
               state_in = jti_pkg::ST_CHECK;
            end
         end
         jti_pkg::ST_CHECK: begin
            if (cnt_ff < 9'd2 || t_ff >= {16'd0, total_ff}) begin
               state_in = jti_pkg::ST_READ;
            end else begin
               state_in = jti_pkg::ST_DIV;
            end
         end
         jti_pkg::ST_DIV: begin
            if (last_step) begin
               state_in = jti_pkg::ST_CLAMP;
            end
         end
         jti_pkg::ST_CLAMP: state_in = jti_pkg::ST_FRAC;
         jti_pkg::ST_FRAC: begin
            if (last_step) begin
               state_in = jti_pkg::ST_READ;
            end
         end
         jti_pkg::ST_READ: state_in = jti_pkg::ST_MUL;
         jti_pkg::ST_MUL:  state_in = jti_pkg::ST_SEND;
         jti_pkg::ST_SEND: begin
            if (out_free) begin
               state_in = (joint_ff == JLAST) ? jti_pkg::ST_IDLE : jti_pkg::ST_READ;
            end
         end
         default: state_in = jti_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      start_in     = start_ff;
      pend_in      = pend_ff;
      active_in    = active_ff;
      t_in         = t_ff;
      tnlo_in      = tnlo_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      frac_in      = frac_ff;
      step_in      = step_ff;
      base_in      = base_ff;
      joint_in     = joint_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      wr_addr      = jti_pkg::ADDR_W'(req_data.point_index) * JSTEP
                     + jti_pkg::ADDR_W'(req_data.joint_index);
      rd_addr0     = base_ff + jti_pkg::ADDR_W'(joint_ff);
      rd_addr1     = end_ff ? rd_addr0 : (rd_addr0 + JSTEP);
      case (state_ff)
         jti_pkg::ST_IDLE: begin
            if (req_fire && req_data.req_type == jti_pkg::REQ_LOAD) begin
               // Loads outside the joint or point range are dropped.
               if (32'(req_data.joint_index) < 32'(jti_pkg::JOINTS) &&
                   32'(req_data.point_index) < 32'(jti_pkg::MAX_POINTS)) begin
                  mem_we = 1'b1;
                  if (req_data.point_index == 8'd0) begin
                     active_in = 1'b0;
                     cnt_in    = 9'd0;
                  end
                  if (req_data.is_last_point) begin
                     cnt_in    = {1'b0, req_data.point_index} + 9'd1;
                     total_in  = req_data.point_time_us;
                     pend_in   = 1'b1;
                     active_in = 1'b1;
                  end
               end
            end else if (req_fire) begin
               start_in = start_now;
               pend_in  = 1'b0;
               t_in     = req_data.now_time_us - start_now;
            end
         end
         jti_pkg::ST_CHECK: begin
            joint_in = 3'd0;
            step_in  = 5'd0;
            if (cnt_ff < 9'd2 || t_ff >= {16'd0, total_ff}) begin
               // End of trajectory: hold the last point, then clear.
               end_in    = 1'b1;
               frac_in   = 17'd0;
               base_in   = jti_pkg::ADDR_W'(last_pt) * JSTEP;
               active_in = 1'b0;
               cnt_in    = 9'd0;
            end else begin
               end_in  = 1'b0;
               rem_in  = tn[40:8];
               tnlo_in = tn[7:0];
            end
         end
         jti_pkg::ST_DIV: begin
            rem_in  = div_r2;
            q_in    = {q_ff[6:0], div_ge};
            tnlo_in = {tnlo_ff[6:0], 1'b0};
            step_in = last_step ? 5'd0 : (step_ff + 5'd1);
         end
         jti_pkg::ST_CLAMP: begin
            // The last segment takes the tail of the time as well.
            base_in = jti_pkg::ADDR_W'(ind_c) * JSTEP;
            if (ind_c != q_ff) begin
               rem_in = rem_ff + {1'b0, total_ff};
            end
         end
         jti_pkg::ST_FRAC: begin
            rem_in  = div_r2;
            frac_in = {frac_ff[15:0], div_ge};
            step_in = step_ff + 5'd1;
            if (last_step && {frac_ff[15:0], div_ge} > 17'(jti_pkg::ONE_Q16)) begin
               frac_in = 17'(jti_pkg::ONE_Q16);
            end
         end
         jti_pkg::ST_READ: rd_en = 1'b1;
         jti_pkg::ST_MUL: ;
         jti_pkg::ST_SEND: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.out_joint    = joint_ff;
               rsp_data_in.position_cmd = pa_keep_ff + pprod_ff[47:16];
               rsp_data_in.velocity_cmd = end_ff ? 32'sd0 : (va_keep_ff + vprod_ff[47:16]);
               rsp_data_in.motion_done  = end_ff;
               rsp_data_in.last_of_tick = (joint_ff == JLAST);
               joint_in                 = joint_ff + 3'd1;
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jti_pkg::ST_IDLE;
         cnt_ff       <= 9'd0;
         total_ff     <= 32'd0;
         start_ff     <= 48'd0;
         pend_ff      <= 1'b0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= 5'd0;
         joint_ff     <= 3'd0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         start_ff     <= start_in;
         pend_ff      <= pend_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         joint_ff     <= joint_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      tnlo_ff     <= tnlo_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      frac_ff     <= frac_in;
      base_ff     <= base_in;
      end_ff      <= end_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Point memories: one write port, two registered read ports each.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pos_mem[wr_addr] <= req_data.position_in;
         vel_mem[wr_addr] <= req_data.velocity_in;
      end
      if (rd_en) begin
         pa_ff <= pos_mem[rd_addr0];
         pb_ff <= pos_mem[rd_addr1];
         va_ff <= vel_mem[rd_addr0];
         vb_ff <= vel_mem[rd_addr1];
      end
   end

   // Interpolation: a + floor((b - a) * f / 2^16).
   always_ff @(posedge clock) begin
      if (state_ff == jti_pkg::ST_MUL) begin
         pa_keep_ff <= pa_ff;
         va_keep_ff <= va_ff;
         pprod_ff   <= 51'((33'(pb_ff) - 33'(pa_ff)) * $signed({1'b0, frac_ff}));
         vprod_ff   <= 51'((33'(vb_ff) - 33'(va_ff)) * $signed({1'b0, frac_ff}));
      end
   end

`ifndef SYNTHESIS
   a_last_joint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_tick |-> rsp_data.out_joint == JLAST)
      else $error("last_of_tick on a word that is not the last joint");
   a_end_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.motion_done |-> rsp_data.velocity_cmd == 32'sd0)
      else $error("nonzero velocity at trajectory end");
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == jti_pkg::ST_DIV |-> rem_ff < {1'b0, total_ff})
      else $error("segment divide remainder out of range");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == jti_pkg::ST_SEND && !out_free |=> state_ff == jti_pkg::ST_SEND)
      else $error("sequencer left a blocked send");
`endif

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import jti_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int END_WAIT       = 200;
   localparam int RANDOM_ITEMS   = 66;

   typedef struct {
      req_word_type word;
      bit           drain;
   } pending_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;

   pending_word_type pending_words[$];
   rsp_word_type     expected_cmds[$];

   // Trajectory state as the interpolator should hold it.
   logic signed [31:0] point_position [DEPTH];
   logic signed [31:0] point_velocity [DEPTH];
   int unsigned        point_count;
   logic [31:0]        traj_span;
   logic [47:0]        start_time;
   bit                 start_pending;
   bit                 traj_active;

   int send_idle_pct = 32;
   int recv_idle_pct = 57;
   int mismatches = 0;
   int cmds_checked = 0;
   int ticks_sent = 0;
   int loads_sent = 0;
   int end_cmds = 0;
   int idle_cycles = 0;

   joint_trajectory_interpolator_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // Floor of (a*(1-f) + b*f), with f in unsigned Q1.16.
   function automatic logic signed [31:0] blend_q16(logic signed [31:0] a,
                                                     logic signed [31:0] b,
                                                     logic [16:0] frac);
      logic signed [63:0] acc;
      acc = 64'(a) * $signed({47'd0, 17'(ONE_Q16 - frac)}) + 64'(b) * $signed({47'd0, frac});
      return 32'(acc >>> 16);
   endfunction

   // Work out the joint commands caused by one accepted word.
   function automatic void interpolate_word(req_word_type w);
      int unsigned a, last, base0;
      logic [63:0] elapsed, tn, seg, num, frac64;
      rsp_word_type c;
      if (w.req_type == REQ_LOAD) begin
         if (w.joint_index >= JOINTS || w.point_index >= MAX_POINTS) return;
         if (w.point_index == 0) begin
            traj_active = 0;
            point_count = 0;
         end
         a = w.point_index * JOINTS + w.joint_index;
         point_position[a] = w.position_in;
         point_velocity[a] = w.velocity_in;
         if (w.is_last_point) begin
            point_count = w.point_index + 1;
            traj_span = w.point_time_us;
            start_pending = 1;
            traj_active = 1;
         end
         return;
      end
      if (start_pending) begin
         start_time = w.now_time_us;
         start_pending = 0;
      end
      if (!traj_active) return;
      elapsed = 64'(48'(w.now_time_us - start_time));
      if (point_count < 2 || elapsed >= 64'(traj_span)) begin
         last = (point_count >= 1) ? point_count - 1 : 0;
         for (int j = 0; j < JOINTS; j++) begin
            c.out_joint = 3'(j);
            c.position_cmd = point_position[last * JOINTS + j];
            c.velocity_cmd = '0;
            c.motion_done = 1'b1;
            c.last_of_tick = (j == JOINTS - 1);
            expected_cmds = {expected_cmds, c};
         end
         traj_active = 0;
         point_count = 0;
         return;
      end
      tn = elapsed * point_count;
      seg = tn / traj_span;
      if (seg > 64'(point_count - 2)) seg = 64'(point_count - 2);
      num = tn - seg * traj_span;
      frac64 = (num * ONE_Q16) / traj_span;
      if (frac64 > ONE_Q16) frac64 = 64'(ONE_Q16);
      base0 = int'(seg) * JOINTS;
      for (int j = 0; j < JOINTS; j++) begin
         c.out_joint = 3'(j);
         c.position_cmd = blend_q16(point_position[base0 + j],
                                    point_position[base0 + JOINTS + j], 17'(frac64));
         c.velocity_cmd = blend_q16(point_velocity[base0 + j],
                                    point_velocity[base0 + JOINTS + j], 17'(frac64));
         c.motion_done = 1'b0;
         c.last_of_tick = (j == JOINTS - 1);
         expected_cmds = {expected_cmds, c};
      end
   endfunction

   task automatic queue_load(int p, int j, logic [31:0] pos, logic [31:0] vel,
                             logic [31:0] tm, bit last);
      pending_word_type pw;
      pw.word = '0;
      pw.word.req_type = REQ_LOAD;
      pw.word.point_index = 8'(p);
      pw.word.joint_index = 3'(j);
      pw.word.position_in = pos;
      pw.word.velocity_in = vel;
      pw.word.point_time_us = tm;
      pw.word.is_last_point = last;
      pw.word.now_time_us = 48'({$urandom, $urandom});
      pw.drain = 1'b0;
      pending_words = {pending_words, pw};
   endtask

   task automatic queue_tick(logic [47:0] now, bit drain);
      pending_word_type pw;
      logic [159:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
      pw.word = noise[$bits(req_word_type)-1:0];
      pw.word.req_type = REQ_TICK;
      pw.word.now_time_us = now;
      pw.drain = drain;
      pending_words = {pending_words, pw};
   endtask

   // Load every joint of points 0..n-1; the final load marks the last point.
   task automatic queue_trajectory(int n, logic [31:0] total, bit extreme);
      logic [31:0] pos, vel;
      for (int p = 0; p < n; p++) begin
         for (int j = 0; j < JOINTS; j++) begin
            pos = $urandom;
            vel = $urandom;
            if (extreme) begin
               pos = p[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
               vel = p[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            queue_load(p, j, pos, vel, total, (p == n - 1) && (j == JOINTS - 1));
         end
      end
   endtask

   // Ticks measured from a random base, spread a little past the end.
   task automatic queue_ticks(int count, logic [31:0] total);
      logic [47:0] base;
      logic [63:0] span;
      base = 48'({$urandom, $urandom});
      span = 64'(total) + 64'(total) / 8 + 1;
      queue_tick(base, 1'b0);
      for (int k = 1; k < count; k++)
         queue_tick(base + 48'({$urandom, $urandom} % span),
                    k == count - 1 && $urandom_range(3) == 0);
   endtask

   // Driver: present the next word when the channel is free.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct &&
             !(pending_words[0].drain &&
               (expected_cmds.size() > 0 || (req_valid && req_ready)))) begin
            req_data <= pending_words[0].word;
            req_valid <= 1'b1;
            void'(pending_words.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stalls at random.
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Predict on each accepted word, check each accepted command.
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (req_data.req_type == REQ_TICK) ticks_sent++;
            else loads_sent++;
            interpolate_word(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_cmds.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected command word joint=%0d pos=%h vel=%h",
                           rsp_data.out_joint, rsp_data.position_cmd, rsp_data.velocity_cmd);
            end else begin
               e = expected_cmds.pop_front();
               cmds_checked++;
               if (e.motion_done) end_cmds++;
               if (rsp_data !== e) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("ERROR: joint exp=%0d got=%0d pos exp=%h got=%h vel exp=%h got=%h",
                              e.out_joint, rsp_data.out_joint, e.position_cmd,
                              rsp_data.position_cmd, e.velocity_cmd, rsp_data.velocity_cmd);
                     $display("       end exp=%b got=%b last exp=%b got=%b",
                              e.motion_done, rsp_data.motion_done, e.last_of_tick,
                              rsp_data.last_of_tick);
                  end
               end
            end
         end
      end
   end

   // Watchdog on cycles with no word moving.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || expected_cmds.size() > 0)
         @(posedge clock);
   endtask

   // Random phase: mostly whole trajectories, some noise loads and ticks.
   task automatic random_phase(int items);
      int start_count, n;
      logic [31:0] total;
      start_count = pending_words.size() + loads_sent + ticks_sent;
      while (pending_words.size() + loads_sent + ticks_sent - start_count < items) begin
         case ($urandom_range(9))
            0: queue_load($urandom_range(255), $urandom_range(7), $urandom, $urandom,
                          $urandom, 1'b0);
            1: queue_tick(48'({$urandom, $urandom}), 1'b0);
            default: begin
               n = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 4);
               total = ($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 200000);
               queue_trajectory(n, total, 1'b0);
               queue_ticks($urandom_range(2, 6), total);
            end
         endcase
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty tick, bad joints, top point, extreme values.
      queue_tick(48'hFFFF_FFFF_FFFF, 1'b0);
      queue_load(3, 6, 32'h1234_5678, 32'h1, 32'd5, 1'b1);
      queue_load(0, 7, '1, '1, '1, 1'b1);
      queue_load(255, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      queue_trajectory(2, 32'd1000, 1'b1);
      queue_tick(48'h8000_0000_0000, 1'b0);
      queue_tick(48'h8000_0000_01F4, 1'b0);
      queue_tick(48'h7FFF_FFFF_FFFF, 1'b1);
      wait_drained();

      random_phase(RANDOM_ITEMS / 3);
      wait_drained();
      send_idle_pct = 57;
      recv_idle_pct = 32;
      random_phase(RANDOM_ITEMS / 3);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(RANDOM_ITEMS / 3);

      wait_drained();
      repeat (END_WAIT) @(posedge clock);
      mismatches += expected_cmds.size();
      $display("Ran %0d point loads and %0d ticks; checked %0d joint words, %0d at end.",
               loads_sent, ticks_sent, cmds_checked, end_cmds);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
